>>> src/etds_pkg.sv
// Shared types, codes and constants of the elevation tile decoder and sampler.
// Used by every module in this folder; depends on nothing else.
package etds_pkg;

    // Default tile side limit, handed to the top level's parameter.
    localparam int MAX_SIDE_DEF = 256;

    // Field widths.
    localparam int PIX_W    = 8;
    localparam int COORD_W  = 17;
    localparam int ELEV_W   = 24;
    localparam int RUN_W    = 25;
    localparam int FRAC_W   = 16;
    localparam int STAT_W   = 2;

    // Configuration port.
    localparam int CFG_W      = 9;
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TILE_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TILE_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]      CFG_SIDE_RST    = 9'd256;

    // Commands and status codes.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;
    localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INCOMPLETE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW   = 2'd2;

    // 1.0 in Q1.16.
    localparam logic [COORD_W-1:0] ONE_Q16 = 17'h10000;

    // Running minimum and maximum start outside the output range.
    localparam logic signed [RUN_W-1:0] RUN_MIN_RST = 25'sh0FFFFFF;
    localparam logic signed [RUN_W-1:0] RUN_MAX_RST = 25'sh1000000;
    localparam logic signed [RUN_W-1:0] RUN_OUT_HI  = 25'sh07FFFFF;
    localparam logic signed [RUN_W-1:0] RUN_OUT_LO  = 25'sh1800000;

    // Shared multiply-add unit: p = a * b + c.
    localparam int MAC_A_W = 25;
    localparam int MAC_B_W = 18;
    localparam int MAC_P_W = 43;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TOTAL,
        ST_LOAD,
        ST_FX,
        ST_FY,
        ST_ROW0,
        ST_ROW1,
        ST_E00,
        ST_E01,
        ST_E10,
        ST_E11,
        ST_VTOP,
        ST_VBOT,
        ST_DONE
    } t_state;

    // Clips a running value to the 24-bit output range.
    function automatic logic signed [ELEV_W-1:0] sat_elev(input logic signed [RUN_W-1:0] v);
        logic signed [ELEV_W-1:0] res;
        if (v > RUN_OUT_HI) begin
            res = RUN_OUT_HI[ELEV_W-1:0];
        end else if (v < RUN_OUT_LO) begin
            res = RUN_OUT_LO[ELEV_W-1:0];
        end else begin
            res = v[ELEV_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> src/etds_mac.sv
// Shared signed multiply-add unit, p = a * b + c, used by the sequencer's size, position and interpolation steps.
// Depends on etds_pkg for the operand widths.
module etds_mac import etds_pkg::*; (
    input  logic signed [MAC_A_W-1:0] i_a,
    input  logic signed [MAC_B_W-1:0] i_b,
    input  logic signed [MAC_P_W-1:0] i_c,
    output logic signed [MAC_P_W-1:0] o_p
);

    logic signed [MAC_P_W-1:0] prod;

    assign prod = MAC_P_W'(i_a * i_b);
    assign o_p  = prod + i_c;

endmodule

>>> src/etds_store.sv
// Single-port tile memory: one write or one read per cycle, read data registered.
// Depends on etds_pkg for the elevation width.
module etds_store import etds_pkg::*; #(
    parameter int DEPTH = MAX_SIDE_DEF * MAX_SIDE_DEF,
    parameter int AW    = $clog2(MAX_SIDE_DEF * MAX_SIDE_DEF)
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_addr,
    input  logic signed [ELEV_W-1:0] i_wdata,
    output logic signed [ELEV_W-1:0] o_rdata
);

    logic signed [ELEV_W-1:0] r_mem [DEPTH];
    logic signed [ELEV_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/elevation_tile_decode_sample.sv
// Load beat: states total, load and done. Sample beat: total, fx, fy, row0, row1, e00 to
// e11, vtop, vbot and done; on an incomplete tile fx goes straight to done. New beats
// are taken only in idle; all steps share the multiply-add unit and single-port memory.
// Reset (synchronous, active low) empties the tile and sets both sides to 256.
// The tile memory needs no clearing pass; only entries already loaded are ever read.
//
// Top level: sequencer, pointer and min/max bookkeeping, output register.
// Depends on etds_pkg, etds_mac and etds_store.
module elevation_tile_decode_sample import etds_pkg::*; #(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // red[7:0], green[15:8], blue[23:16], u_coord[40:24], v_coord[57:41], zero pad
    input  logic [63:0]           i_s_tdata,
    // cmd[0], first_pixel[1]
    input  logic [1:0]            i_s_tuser,
    // Result stream.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // elevation[23:0], min_elevation[47:24], max_elevation[71:48]
    output logic [71:0]           o_m_tdata,
    // status[1:0]
    output logic [1:0]            o_m_tuser,
    // Configuration writes.
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);

    // Side width holds MAX_SIDE itself; the compare width covers both the register and it.
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int CW    = (SW > CFG_W) ? SW : CFG_W;
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(DEPTH + 1);

    // ------------------------------------------------------------------
    // Input beat fields.
    // ------------------------------------------------------------------
    logic               s_cmd;
    logic               s_first;
    logic [PIX_W-1:0]   s_red;
    logic [PIX_W-1:0]   s_green;
    logic [PIX_W-1:0]   s_blue;
    logic [COORD_W-1:0] s_u;
    logic [COORD_W-1:0] s_v;

    assign s_cmd   = i_s_tuser[0];
    assign s_first = i_s_tuser[1];
    assign s_red   = i_s_tdata[7:0];
    assign s_green = i_s_tdata[15:8];
    assign s_blue  = i_s_tdata[23:16];
    assign s_u     = i_s_tdata[40:24];
    assign s_v     = i_s_tdata[57:41];

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    t_state                   r_state, n_state;
    logic [CFG_W-1:0]         r_tile_width;
    logic [CFG_W-1:0]         r_tile_height;
    logic [PW-1:0]            r_ptr, n_ptr;
    logic signed [RUN_W-1:0]  r_min, n_min;
    logic signed [RUN_W-1:0]  r_max, n_max;
    logic                     r_o_valid, n_o_valid;

    logic                     r_cmd;
    logic                     r_first;
    logic signed [ELEV_W-1:0] r_pix;
    logic [COORD_W-1:0]       r_u;
    logic [COORD_W-1:0]       r_v;
    logic [PW-1:0]            r_total;
    logic [SW-1:0]            r_x0;
    logic [SW-1:0]            r_y0;
    logic [FRAC_W-1:0]        r_tx;
    logic [FRAC_W-1:0]        r_ty;
    logic                     r_dx;
    logic [AW-1:0]            r_base0;
    logic [AW-1:0]            r_base1;
    logic signed [MAC_P_W-1:0] r_acc;
    logic signed [ELEV_W-1:0] r_top;
    logic signed [ELEV_W-1:0] r_bot;
    logic signed [ELEV_W-1:0] r_result;
    logic [STAT_W-1:0]        r_status;
    logic [71:0]              r_o_data;
    logic [STAT_W-1:0]        r_o_status;

    // ------------------------------------------------------------------
    // Effective tile sides: zero acts as one, anything above MAX_SIDE as MAX_SIDE.
    // ------------------------------------------------------------------
    logic [SW-1:0] side_w;
    logic [SW-1:0] side_h;

    always_comb begin
        if (r_tile_width == '0) begin
            side_w = SW'(1);
        end else if (CW'(r_tile_width) > CW'(MAX_SIDE)) begin
            side_w = SW'(MAX_SIDE);
        end else begin
            side_w = SW'(r_tile_width);
        end
        if (r_tile_height == '0) begin
            side_h = SW'(1);
        end else if (CW'(r_tile_height) > CW'(MAX_SIDE)) begin
            side_h = SW'(MAX_SIDE);
        end else begin
            side_h = SW'(r_tile_height);
        end
    end

    // ------------------------------------------------------------------
    // Small helpers around the neighbour positions. The right and lower
    // neighbours fall back onto the edge column or row of the tile.
    // ------------------------------------------------------------------
    logic [SW:0]   x0_inc;
    logic [SW:0]   y0_inc;
    logic          dx_next;
    logic          dy;
    logic [SW-1:0] y1;

    assign x0_inc  = {1'b0, r_x0} + (SW+1)'(1);
    assign y0_inc  = {1'b0, r_y0} + (SW+1)'(1);
    assign dx_next = x0_inc < {1'b0, side_w};
    assign dy      = y0_inc < {1'b0, side_h};
    assign y1      = r_y0 + SW'(dy);

    // Load bookkeeping: a restart clears the pointer and the running extremes first.
    logic [PW-1:0]           eff_ptr;
    logic                    overflow;
    logic signed [RUN_W-1:0] base_min;
    logic signed [RUN_W-1:0] base_max;
    logic signed [RUN_W-1:0] pix_ext;
    logic                    incomplete;

    assign eff_ptr    = r_first ? '0 : r_ptr;
    assign overflow   = eff_ptr >= r_total;
    assign base_min   = r_first ? RUN_MIN_RST : r_min;
    assign base_max   = r_first ? RUN_MAX_RST : r_max;
    assign pix_ext    = RUN_W'(r_pix);
    assign incomplete = r_ptr < r_total;

    // ------------------------------------------------------------------
    // Shared multiply-add unit and tile memory.
    // ------------------------------------------------------------------
    logic signed [MAC_A_W-1:0] mac_a;
    logic signed [MAC_B_W-1:0] mac_b;
    logic signed [MAC_P_W-1:0] mac_c;
    logic signed [MAC_P_W-1:0] mac_p;
    logic                      mem_we;
    logic [AW-1:0]             mem_addr;
    logic signed [ELEV_W-1:0]  mem_q;
    logic [COORD_W-1:0]        tx_inv;
    logic [COORD_W-1:0]        ty_inv;
    logic                      out_load;

    etds_mac u_mac (
        .i_a (mac_a),
        .i_b (mac_b),
        .i_c (mac_c),
        .o_p (mac_p)
    );

    etds_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (r_pix),
        .o_rdata (mem_q)
    );

    // Weights of the near neighbour in each interpolation: 1.0 minus the fraction.
    assign tx_inv = ONE_Q16 - {1'b0, r_tx};
    assign ty_inv = ONE_Q16 - {1'b0, r_ty};

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_TOTAL;
                end
            end
            ST_TOTAL: begin
                n_state = (r_cmd == CMD_SAMPLE) ? ST_FX : ST_LOAD;
            end
            ST_LOAD:  n_state = ST_DONE;
            ST_FX:    n_state = incomplete ? ST_DONE : ST_FY;
            ST_FY:    n_state = ST_ROW0;
            ST_ROW0:  n_state = ST_ROW1;
            ST_ROW1:  n_state = ST_E00;
            ST_E00:   n_state = ST_E01;
            ST_E01:   n_state = ST_E10;
            ST_E10:   n_state = ST_E11;
            ST_E11:   n_state = ST_VTOP;
            ST_VTOP:  n_state = ST_VBOT;
            ST_VBOT:  n_state = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs: operand selection for the shared unit and memory port.
    // Each lerp is a*(1-t) + b*t over two passes, then a floor shift by 16.
    // ------------------------------------------------------------------
    always_comb begin
        mac_a    = '0;
        mac_b    = '0;
        mac_c    = '0;
        mem_we   = 1'b0;
        mem_addr = r_base0;
        case (r_state)
            ST_TOTAL: begin
                mac_a = $signed({{(MAC_A_W-SW){1'b0}}, side_w});
                mac_b = $signed({{(MAC_B_W-SW){1'b0}}, side_h});
            end
            ST_LOAD: begin
                mem_we   = !overflow;
                mem_addr = eff_ptr[AW-1:0];
            end
            ST_FX: begin
                mac_a = $signed({{(MAC_A_W-COORD_W){1'b0}}, r_u});
                mac_b = $signed({{(MAC_B_W-SW){1'b0}}, side_w - SW'(1)});
            end
            ST_FY: begin
                mac_a = $signed({{(MAC_A_W-COORD_W){1'b0}}, r_v});
                mac_b = $signed({{(MAC_B_W-SW){1'b0}}, side_h - SW'(1)});
            end
            ST_ROW0: begin
                mac_a = $signed({{(MAC_A_W-SW){1'b0}}, r_y0});
                mac_b = $signed({{(MAC_B_W-SW){1'b0}}, side_w});
                mac_c = $signed({{(MAC_P_W-SW){1'b0}}, r_x0});
            end
            ST_ROW1: begin
                mac_a    = $signed({{(MAC_A_W-SW){1'b0}}, y1});
                mac_b    = $signed({{(MAC_B_W-SW){1'b0}}, side_w});
                mac_c    = $signed({{(MAC_P_W-SW){1'b0}}, r_x0});
                mem_addr = r_base0;
            end
            ST_E00: begin
                mac_a    = MAC_A_W'(mem_q);
                mac_b    = $signed({{(MAC_B_W-COORD_W){1'b0}}, tx_inv});
                mem_addr = r_base0 + AW'(r_dx);
            end
            ST_E01: begin
                mac_a    = MAC_A_W'(mem_q);
                mac_b    = $signed({{(MAC_B_W-FRAC_W){1'b0}}, r_tx});
                mac_c    = r_acc;
                mem_addr = r_base1;
            end
            ST_E10: begin
                mac_a    = MAC_A_W'(mem_q);
                mac_b    = $signed({{(MAC_B_W-COORD_W){1'b0}}, tx_inv});
                mem_addr = r_base1 + AW'(r_dx);
            end
            ST_E11: begin
                mac_a = MAC_A_W'(mem_q);
                mac_b = $signed({{(MAC_B_W-FRAC_W){1'b0}}, r_tx});
                mac_c = r_acc;
            end
            ST_VTOP: begin
                mac_a = MAC_A_W'(r_top);
                mac_b = $signed({{(MAC_B_W-COORD_W){1'b0}}, ty_inv});
            end
            ST_VBOT: begin
                mac_a = MAC_A_W'(r_bot);
                mac_b = $signed({{(MAC_B_W-FRAC_W){1'b0}}, r_ty});
                mac_c = r_acc;
            end
            default: begin
                mac_a = '0;
            end
        endcase
    end

    // The output register takes a finished beat whenever it is empty or being drained.
    assign out_load   = (r_state == ST_DONE) && (!r_o_valid || i_m_tready);
    assign o_s_tready = (r_state == ST_IDLE);

    // ------------------------------------------------------------------
    // Control state: pointer, running extremes, output valid.
    // ------------------------------------------------------------------
    always_comb begin
        n_ptr = r_ptr;
        n_min = r_min;
        n_max = r_max;
        if ((r_state == ST_LOAD) && !overflow) begin
            n_ptr = eff_ptr + PW'(1);
            n_min = (pix_ext < base_min) ? pix_ext : base_min;
            n_max = (pix_ext > base_max) ? pix_ext : base_max;
        end
        if (out_load) begin
            n_o_valid = 1'b1;
        end else if (i_m_tready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_tile_width  <= CFG_SIDE_RST;
            r_tile_height <= CFG_SIDE_RST;
            r_ptr         <= '0;
            r_min         <= RUN_MIN_RST;
            r_max         <= RUN_MAX_RST;
            r_o_valid     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_min     <= n_min;
            r_max     <= n_max;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_TILE_WIDTH:  r_tile_width  <= i_cfg_wdata;
                    CFG_TILE_HEIGHT: r_tile_height <= i_cfg_wdata;
                    default:         r_tile_width  <= r_tile_width;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers. The pixel decode is a flip of the top bit:
    // r*65536 + g*256 + b - 2^23 in 24-bit two's complement.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    r_cmd   <= s_cmd;
                    r_first <= s_first;
                    r_pix   <= {~s_red[PIX_W-1], s_red[PIX_W-2:0], s_green, s_blue};
                    r_u     <= (s_u > ONE_Q16) ? ONE_Q16 : s_u;
                    r_v     <= (s_v > ONE_Q16) ? ONE_Q16 : s_v;
                end
            end
            ST_TOTAL: begin
                r_total <= mac_p[PW-1:0];
            end
            ST_LOAD: begin
                r_result <= r_pix;
                r_status <= overflow ? STAT_OVERFLOW : STAT_OK;
            end
            ST_FX: begin
                r_x0     <= mac_p[FRAC_W +: SW];
                r_tx     <= mac_p[FRAC_W-1:0];
                r_result <= '0;
                r_status <= STAT_INCOMPLETE;
            end
            ST_FY: begin
                r_y0 <= mac_p[FRAC_W +: SW];
                r_ty <= mac_p[FRAC_W-1:0];
                r_dx <= dx_next;
            end
            ST_ROW0: begin
                r_base0 <= mac_p[AW-1:0];
            end
            ST_ROW1: begin
                r_base1 <= mac_p[AW-1:0];
            end
            ST_E00, ST_E10, ST_VTOP: begin
                r_acc <= mac_p;
            end
            ST_E01: begin
                r_top <= mac_p[FRAC_W +: ELEV_W];
            end
            ST_E11: begin
                r_bot <= mac_p[FRAC_W +: ELEV_W];
            end
            ST_VBOT: begin
                r_result <= mac_p[FRAC_W +: ELEV_W];
                r_status <= STAT_OK;
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
        if (out_load) begin
            r_o_data   <= {sat_elev(r_max), sat_elev(r_min), r_result};
            r_o_status <= r_status;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_status;

endmodule

>>> test/tb_elevation_tile_decode_sample.sv
// Self-checking testbench for elevation_tile_decode_sample: pixel decoding, tile bookkeeping
// and bilinear sampling, checked beat by beat against a behavioural predictor held here.
// Depends on etds_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_elevation_tile_decode_sample;
    import etds_pkg::*;

    // Half of the 12 ns clock period.
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 11;
    // Longest path through the block is a sample beat; the settle time is set to cover it.
    localparam int SETTLE_CYCLES = 20;
    localparam int TILE_CAP      = MAX_SIDE_DEF * MAX_SIDE_DEF;
    localparam int ELEV_OFFSET   = 8388608;
    localparam int RUN_LOW_INIT  = 16777215;
    localparam int RUN_HIGH_INIT = -16777216;
    // The directed tests send some 600 beats; the random part brings the total near 1700.
    localparam int RANDOM_BEATS  = 1100;
    // Random gaps on both sides and the steps of each sample still leave the whole run
    // far shorter than the watchdog limit.
    localparam int WATCHDOG_NS   = 12_000_000;

    // One expected result beat.
    typedef struct {
        logic signed [ELEV_W-1:0] elev;
        logic signed [ELEV_W-1:0] lowest;
        logic signed [ELEV_W-1:0] highest;
        logic [STAT_W-1:0]        status;
    } t_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    // red[7:0], green[15:8], blue[23:16], u_coord[40:24], v_coord[57:41], zero pad
    logic [63:0]           i_s_tdata;
    // cmd[0], first_pixel[1]
    logic [1:0]            i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    // elevation[23:0], min_elevation[47:24], max_elevation[71:48]
    logic [71:0]           o_m_tdata;
    // status[1:0]
    logic [1:0]            o_m_tuser;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]      i_cfg_wdata;

    // Predictor state: the tile as the block should hold it.
    int          tile_mem [TILE_CAP];
    int unsigned fill_ptr;
    int          run_low;
    int          run_high;
    logic [CFG_W-1:0] side_w_reg;
    logic [CFG_W-1:0] side_h_reg;

    // Results predicted but not yet seen on the output stream, oldest first.
    t_result awaited_results [$];

    // Handshake pacing shared between the stimulus and the two stream processes.
    bit tx_gaps_on    = 1'b1;
    bit rx_gaps_on    = 1'b1;
    int rx_wait       = 0;
    int hold_request  = 0;

    // Run statistics.
    int fail_count       = 0;
    int beats_sent       = 0;
    int results_checked  = 0;
    int loads_sent       = 0;
    int samples_sent     = 0;
    int settings_count   = 0;
    int ok_count         = 0;
    int incomplete_count = 0;
    int overflow_count   = 0;

    elevation_tile_decode_sample u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #HALF_PERIOD;
        i_clk = 1'b0;
        #HALF_PERIOD;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A side register of 0 behaves as 1 and anything above the maximum as the maximum.
    function automatic int unsigned usable_side(input logic [CFG_W-1:0] code);
        if (code == '0) begin
            return 1;
        end else if (code > MAX_SIDE_DEF) begin
            return MAX_SIDE_DEF;
        end
        return code;
    endfunction

    // The running extremes start outside the 24-bit range and are clipped on output.
    function automatic logic signed [ELEV_W-1:0] clip_elev(input int v);
        if (v > 8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -8388608) begin
            return 24'sh800000;
        end
        return v[ELEV_W-1:0];
    endfunction

    // Linear step a + (b - a) * t / 65536, rounded towards minus infinity.
    // The arithmetic shift of a signed value is exactly that floor.
    function automatic int lerp_down(input int a, input int b, input int unsigned t);
        longint acc;
        acc = longint'(a) * 65536 + (longint'(b) - longint'(a)) * longint'(t);
        return int'(acc >>> FRAC_W);
    endfunction

    function automatic void clear_tile_model();
        fill_ptr   = 0;
        run_low    = RUN_LOW_INIT;
        run_high   = RUN_HIGH_INIT;
        side_w_reg = CFG_SIDE_RST;
        side_h_reg = CFG_SIDE_RST;
    endfunction

    // Applies one accepted input beat to the predicted tile and returns the result beat.
    function automatic t_result decode_or_sample(input logic cmd, input logic restart,
                                                 input logic [PIX_W-1:0] r, g, b,
                                                 input logic [COORD_W-1:0] u, v);
        t_result     res;
        int unsigned w, h, total, uc, vc, fx, fy, x0, y0, x1, y1, tx, ty;
        int          elev, top, bot;
        w     = usable_side(side_w_reg);
        h     = usable_side(side_h_reg);
        total = w * h;
        elev  = 0;
        res.status = STAT_OK;
        if (cmd == CMD_LOAD) begin
            loads_sent++;
            elev = $signed({8'd0, r, g, b}) - ELEV_OFFSET;
            if (restart) begin
                fill_ptr = 0;
                run_low  = RUN_LOW_INIT;
                run_high = RUN_HIGH_INIT;
            end
            if (fill_ptr >= total) begin
                // Tile already full: the pixel is reported back but not kept.
                res.status = STAT_OVERFLOW;
            end else begin
                tile_mem[fill_ptr] = elev;
                fill_ptr++;
                if (elev < run_low) run_low = elev;
                if (elev > run_high) run_high = elev;
            end
        end else begin
            samples_sent++;
            if (fill_ptr < total) begin
                res.status = STAT_INCOMPLETE;
            end else begin
                uc = (u > ONE_Q16) ? ONE_Q16 : u;
                vc = (v > ONE_Q16) ? ONE_Q16 : v;
                fx = uc * (w - 1);
                fy = vc * (h - 1);
                x0 = fx >> FRAC_W;
                y0 = fy >> FRAC_W;
                tx = fx & 32'hFFFF;
                ty = fy & 32'hFFFF;
                x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
                y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
                top  = lerp_down(tile_mem[y0 * w + x0], tile_mem[y0 * w + x1], tx);
                bot  = lerp_down(tile_mem[y1 * w + x0], tile_mem[y1 * w + x1], tx);
                elev = lerp_down(top, bot, ty);
            end
        end
        case (res.status)
            STAT_OK:         ok_count++;
            STAT_INCOMPLETE: incomplete_count++;
            default:         overflow_count++;
        endcase
        res.elev    = clip_elev(elev);
        res.lowest  = clip_elev(run_low);
        res.highest = clip_elev(run_high);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready pacing and checking
    // ------------------------------------------------------------------

    // Ready is driven on the falling edge. A hold-off request from the stimulus is
    // copied into a local count so that this process alone decides its length.
    initial begin : result_ready_gen
        int hold_left;
        hold_left  = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Every result beat is compared with the oldest prediction, field by field.
    always @(posedge i_clk) begin : result_check
        t_result                  want;
        logic signed [ELEV_W-1:0] got_elev, got_low, got_high;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_elev = $signed(o_m_tdata[23:0]);
            got_low  = $signed(o_m_tdata[47:24]);
            got_high = $signed(o_m_tdata[71:48]);
            if (awaited_results.size() == 0) begin
                $error("result beat with nothing expected: elevation %0d status %0d",
                       got_elev, o_m_tuser);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                results_checked++;
                if (got_elev !== want.elev) begin
                    $error("elevation: expected %0d, got %0d", want.elev, got_elev);
                    fail_count++;
                end
                if (got_low !== want.lowest) begin
                    $error("min_elevation: expected %0d, got %0d", want.lowest, got_low);
                    fail_count++;
                end
                if (got_high !== want.highest) begin
                    $error("max_elevation: expected %0d, got %0d", want.highest, got_high);
                    fail_count++;
                end
                if (o_m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_m_tuser);
                    fail_count++;
                end
            end
            rx_wait = rx_gaps_on ? $urandom_range(0, 10) : 0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. Each is entered and left at a falling edge.
    // ------------------------------------------------------------------

    // Offers one beat after an optional gap, waits for the handshake and records the
    // predicted result at the edge where the block takes it.
    task automatic send_beat(input logic cmd, input logic restart,
                             input logic [PIX_W-1:0] r, g, b,
                             input logic [COORD_W-1:0] u, v);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  <= {6'd0, v, u, b, g, r};
        i_s_tuser  <= {restart, cmd};
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        awaited_results.insert(awaited_results.size(),
                               decode_or_sample(cmd, restart, r, g, b, u, v));
        beats_sent++;
        @(negedge i_clk);
    endtask

    // Loads carry random coordinates, which the block must ignore.
    task automatic load_px(input logic restart, input logic [PIX_W-1:0] r, g, b);
        send_beat(CMD_LOAD, restart, r, g, b, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // Samples carry a random restart flag and random pixel bytes, all to be ignored.
    task automatic take_sample(input logic [COORD_W-1:0] u, v);
        send_beat(CMD_SAMPLE, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), u, v);
    endtask

    // Lets the block run dry: no beat offered and every prediction answered.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes both side registers on consecutive edges; only called with the block idle.
    task automatic write_sides(input logic [CFG_W-1:0] w_code, h_code);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_TILE_WIDTH;
        i_cfg_wdata <= w_code;
        @(negedge i_clk);
        i_cfg_addr  <= CFG_TILE_HEIGHT;
        i_cfg_wdata <= h_code;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        side_w_reg = w_code;
        side_h_reg = h_code;
        settings_count++;
    endtask

    // Pixel bytes lean towards the extremes so that the decode limits are hit often.
    function automatic logic [PIX_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly inside 0..1, with the edges and the saturating range above 1.0 mixed in.
    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ONE_Q16;
            2:       return COORD_W'($urandom_range(65537, 131071));
            default: return COORD_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // A side code that sometimes uses the out-of-range spellings of 1 and of the maximum.
    function automatic logic [CFG_W-1:0] side_code(input int side);
        if (side == 1 && $urandom_range(0, 3) == 0) begin
            return '0;
        end else if (side == MAX_SIDE_DEF && $urandom_range(0, 1) == 1) begin
            return CFG_W'($urandom_range(MAX_SIDE_DEF + 1, 511));
        end
        return CFG_W'(side);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight after reset the 256 by 256 tile is empty, so a sample is refused and the
    // extremes read as clipped reset values. A 1 by 1 tile (both sides written as 0)
    // then fills with one pixel and turns the next load into an overflow.
    task automatic test_empty_tile();
        take_sample(17'h08000, 17'h08000);
        drain_results();
        write_sides('0, '0);
        take_sample(17'h08000, 17'h08000);
        load_px(1'b0, 8'h00, 8'h00, 8'h00);
        take_sample('0, '0);
        load_px(1'b0, 8'hFF, 8'hFF, 8'hFF);
        take_sample(17'h1FFFF, 17'h1FFFF);
    endtask

    // A 2 by 2 tile holding the extreme elevations, sampled at the corners, the centre,
    // just inside the edges and beyond 1.0; then a restart leaves it incomplete.
    task automatic test_corner_values();
        drain_results();
        write_sides(9'd2, 9'd2);
        load_px(1'b1, 8'hFF, 8'hFF, 8'hFF);
        load_px(1'b0, 8'h00, 8'h00, 8'h00);
        load_px(1'b0, 8'h80, 8'h00, 8'h00);
        load_px(1'b0, 8'h7F, 8'hFF, 8'hFF);
        take_sample('0, '0);
        take_sample(ONE_Q16, ONE_Q16);
        take_sample(ONE_Q16, '0);
        take_sample('0, ONE_Q16);
        take_sample(17'h08000, 17'h08000);
        take_sample(17'h00001, 17'h0FFFF);
        take_sample(17'h0FFFF, 17'h00001);
        take_sample(17'h1FFFF, '0);
        load_px(1'b1, 8'h12, 8'h34, 8'h56);
        take_sample(17'h08000, 17'h08000);
    endtask

    // The widest and the tallest tiles the block allows, each one pixel thick.
    task automatic test_side_extremes();
        int k;
        drain_results();
        write_sides(9'd256, '0);
        for (k = 0; k < MAX_SIDE_DEF; k++) load_px(k == 0, pick_byte(), pick_byte(), pick_byte());
        for (k = 0; k < 6; k++) take_sample(pick_coord(), pick_coord());
        drain_results();
        write_sides(9'd1, 9'd511);
        for (k = 0; k < MAX_SIDE_DEF; k++) load_px(k == 0, pick_byte(), pick_byte(), pick_byte());
        for (k = 0; k < 6; k++) take_sample(pick_coord(), pick_coord());
    endtask

    // Side registers changed after loading act at once: a smaller tile is complete
    // straight away, a larger one is incomplete until the extra pixels arrive.
    task automatic test_resize_after_load();
        int k;
        drain_results();
        write_sides(9'd3, 9'd3);
        for (k = 0; k < 9; k++) load_px(k == 0, pick_byte(), pick_byte(), pick_byte());
        take_sample(pick_coord(), pick_coord());
        drain_results();
        write_sides(9'd2, 9'd4);
        for (k = 0; k < 3; k++) take_sample(pick_coord(), pick_coord());
        drain_results();
        write_sides(9'd4, 9'd4);
        take_sample(pick_coord(), pick_coord());
        for (k = 0; k < 7; k++) load_px(1'b0, pick_byte(), pick_byte(), pick_byte());
        for (k = 0; k < 4; k++) take_sample(pick_coord(), pick_coord());
    endtask

    // The result side stops for a long stretch while beats keep coming back to back,
    // so the block fills up and has to hold off its input.
    task automatic test_output_backpressure();
        int k;
        drain_results();
        write_sides(9'd3, 9'd3);
        tx_gaps_on   = 1'b0;
        hold_request = 300;
        for (k = 0; k < 9; k++) load_px(k == 0, pick_byte(), pick_byte(), pick_byte());
        for (k = 0; k < 20; k++) take_sample(pick_coord(), pick_coord());
        tx_gaps_on = 1'b1;
    endtask

    // Random tiles: mostly complete loads followed by samples, with stray samples during
    // loading, the odd restart in mid-tile, cut-short tiles and overflow loads as noise.
    task automatic test_random_tiles(input int target);
        int start_count, w, h, total, cut, n, k, wide, narrow;
        start_count = beats_sent;
        while (beats_sent - start_count < target) begin
            if ($urandom_range(0, 24) == 0) begin
                wide   = $urandom_range(64, MAX_SIDE_DEF);
                narrow = $urandom_range(1, 2);
                if ($urandom_range(0, 1) == 1) begin
                    w = wide;
                    h = narrow;
                end else begin
                    w = narrow;
                    h = wide;
                end
            end else begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 8);
            end
            drain_results();
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            write_sides(side_code(w), side_code(h));
            total = w * h;
            cut   = ($urandom_range(0, 19) == 0) ? $urandom_range(0, total - 1) : total;
            for (k = 0; k < cut; k++) begin
                if ($urandom_range(0, 15) == 0) take_sample(pick_coord(), pick_coord());
                load_px((k == 0) || ($urandom_range(0, 299) == 0),
                        pick_byte(), pick_byte(), pick_byte());
            end
            n = $urandom_range(2, 10);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 9) == 0) load_px(1'b0, pick_byte(), pick_byte(), pick_byte());
                take_sample(pick_coord(), pick_coord());
            end
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = CFG_TILE_WIDTH;
        i_cfg_wdata = '0;
        clear_tile_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_tile();
        test_corner_values();
        test_side_extremes();
        test_resize_after_load();
        test_output_backpressure();
        test_random_tiles(RANDOM_BEATS);
        drain_results();

        $display("Sent %0d beats (%0d loads, %0d samples) over %0d tile settings; %0d checked.",
                 beats_sent, loads_sent, samples_sent, settings_count, results_checked);
        $display("Statuses seen: %0d ok, %0d incomplete tile, %0d pixel overflow.",
                 ok_count, incomplete_count, overflow_count);
        if (fail_count == 0) begin
            $display("elevation_tile_decode_sample: match");
        end else begin
            $display("elevation_tile_decode_sample: mismatch");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #WATCHDOG_NS;
        $display("Timed out with %0d results still awaited.", awaited_results.size());
        $display("elevation_tile_decode_sample: mismatch");
        $finish;
    end

endmodule

>>> files.f
src/etds_pkg.sv
src/etds_mac.sv
src/etds_store.sv
src/elevation_tile_decode_sample.sv
test/tb_elevation_tile_decode_sample.sv
